>>> hdl/sqre_pkg.sv
// shared types and constants of the sntp query and reply engine
package sqre_pkg;

  localparam int unsigned PACKET_BYTES = 48;
  localparam int unsigned CNT_W        = $clog2(PACKET_BYTES + 1);

  localparam logic [CNT_W-1:0] LAST_BEAT  = CNT_W'(PACKET_BYTES - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(PACKET_BYTES);
  localparam logic [CNT_W-1:0] SEC_FIRST  = CNT_W'(40);
  localparam logic [CNT_W-1:0] FRAC_FIRST = CNT_W'(44);

  localparam logic [7:0]  QUERY_BYTE0     = 8'h23;
  localparam logic [31:0] UNIX_EPOCH_SECS = 32'd2208988800;
  localparam logic [9:0]  MS_PER_SEC      = 10'd1000;
  localparam logic [31:0] TIMEOUT_RESET   = 32'd3000000;
  localparam logic [3:0]  RETRY_RESET     = 4'd3;
  localparam logic [2:0]  MODE_SERVER     = 3'd4;
  localparam logic [2:0]  MODE_BROADCAST  = 3'd5;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RX_BYTE = 2'd2,
    CMD_TX_FAIL = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PENDING   = 3'd1,
    ST_TX_FAIL   = 3'd2,
    ST_BAD_REPLY = 3'd3,
    ST_TIMEOUT   = 3'd4
  } status_e;

  typedef enum logic {
    KIND_TX_BYTE = 1'b0,
    KIND_DONE    = 1'b1
  } kind_e;

  typedef enum logic {
    REG_TIMEOUT = 1'b0,
    REG_RETRY   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] rx_byte;
    logic       rx_end;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic        last;
    status_e     status;
    logic [40:0] unix_ms;
  } res_t;

endpackage

>>> hdl/sqre_if.sv
// request and result channel interfaces
interface sqre_req_if;
  import sqre_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sqre_res_if;
  import sqre_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/sntp_query_reply_engine.sv
// sntp client exchange engine: query bursts, reply capture, timeout and retry
//
// request channel: one command per request (start, tick, received byte, send failed)
// result channel: 48 query bytes per start or resend, or one completion record
// config port: cfg_we_i writes timeout ticks (index 0) or retry limit (index 1)
// a request is registered in the input register, then decoded against the exchange state in the next
// cycle; its first result is loaded into the result register once that register is free
// throughput: one request per cycle for ticks and received bytes that produce no result; a
// request that causes a query burst holds the result register until all 48 query bytes are taken,
// counted by the single burst beat counter; the next request waits in the input register
// reset: engine idle, timeout 3000000 ticks, retry limit 3, no result pending
// a stalled receiver holds the result register; requests that produce nothing
// still drain past it, those that produce results wait in the input register
module sntp_query_reply_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  sqre_pkg::cfg_reg_e cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  sqre_req_if.sink           req,
  sqre_res_if.source         res
);
  import sqre_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_DONE
  } phase_e;

  // configuration
  logic [31:0] timeout_q;
  logic [3:0]  retry_q;

  // input register
  logic s1_valid_q, s1_valid_d;
  req_t s1_q;

  // exchange state
  phase_e           phase_q, phase_d;
  logic [3:0]       resend_q, resend_d;
  logic [31:0]      wait_q, wait_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [2:0]       mode_q, mode_d;
  logic [31:0]      sec_q, sec_d;
  logic [31:0]      frac_q, frac_d;

  // result register
  logic             out_valid_q, out_valid_d;
  kind_e            out_kind_q;
  logic [CNT_W-1:0] beat_q, beat_d;
  status_e          out_status_q;
  logic [40:0]      out_ms_q;

  // decode results
  logic        ld_burst, ld_done, produce;
  status_e     ld_status;
  logic [40:0] ld_ms;

  logic s1_adv, out_take, out_last_take, out_free;

  // received byte datapath
  logic             in_pkt, full, mode_ok, sec_ok;
  logic [CNT_W-1:0] cnt_inc;
  logic [2:0]       mode_nx;
  logic [31:0]      sec_nx, frac_nx, secs_rel, wait_inc;
  logic [41:0]      prod_s, prod_f;
  logic [40:0]      ms_sum;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      retry_q   <= RETRY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TIMEOUT: timeout_q <= cfg_wdata_i;
        REG_RETRY:   retry_q   <= cfg_wdata_i[3:0];
        default:     ;
      endcase
    end
  end

  // capture fields of the datagram, big-endian timestamp
  always_comb begin
    in_pkt  = cnt_q < FULL_COUNT;
    cnt_inc = in_pkt ? cnt_q + 1'b1 : cnt_q;
    full    = cnt_inc == FULL_COUNT;
    mode_nx = (cnt_q == '0) ? s1_q.rx_byte[2:0] : mode_q;
    sec_nx  = (cnt_q >= SEC_FIRST && cnt_q < FRAC_FIRST) ?
              {sec_q[23:0], s1_q.rx_byte} : sec_q;
    frac_nx = (cnt_q >= FRAC_FIRST && cnt_q < FULL_COUNT) ?
              {frac_q[23:0], s1_q.rx_byte} : frac_q;
  end

  assign mode_ok  = mode_nx == MODE_SERVER || mode_nx == MODE_BROADCAST;
  assign sec_ok   = sec_nx >= UNIX_EPOCH_SECS;
  assign secs_rel = sec_nx - UNIX_EPOCH_SECS;
  assign prod_s   = 42'(secs_rel) * 42'(MS_PER_SEC);
  assign prod_f   = 42'(frac_nx) * 42'(MS_PER_SEC);
  // whole seconds in ms plus the fraction scaled to ms
  assign ms_sum   = prod_s[40:0] + 41'(prod_f[41:32]);
  assign wait_inc = wait_q + 32'd1;

  // command decode against the exchange state
  always_comb begin
    phase_d   = phase_q;
    resend_d  = resend_q;
    wait_d    = wait_q;
    cnt_d     = cnt_q;
    mode_d    = mode_q;
    sec_d     = sec_q;
    frac_d    = frac_q;
    ld_burst  = 1'b0;
    ld_done   = 1'b0;
    ld_status = ST_PENDING;
    ld_ms     = '0;
    priority if (s1_q.command == CMD_START) begin
      // start always restarts, also mid-exchange
      phase_d  = PH_WAIT;
      resend_d = '0;
      wait_d   = '0;
      cnt_d    = '0;
      ld_burst = 1'b1;
    end else if (phase_q == PH_WAIT) begin
      unique case (s1_q.command)
        CMD_TICK: begin
          if (wait_inc >= timeout_q) begin
            if (resend_q >= retry_q) begin
              phase_d   = PH_DONE;
              ld_done   = 1'b1;
              ld_status = ST_TIMEOUT;
            end else begin
              resend_d = resend_q + 4'd1;
              wait_d   = '0;
              ld_burst = 1'b1;
            end
          end else begin
            wait_d = wait_inc;
          end
        end
        CMD_TX_FAIL: begin
          phase_d   = PH_DONE;
          ld_done   = 1'b1;
          ld_status = ST_TX_FAIL;
        end
        CMD_RX_BYTE: begin
          mode_d = mode_nx;
          sec_d  = sec_nx;
          frac_d = frac_nx;
          cnt_d  = cnt_inc;
          if (s1_q.rx_end) begin
            // short datagrams are dropped, count restarts either way
            cnt_d = '0;
            if (full) begin
              phase_d = PH_DONE;
              ld_done = 1'b1;
              if (mode_ok && sec_ok) begin
                ld_status = ST_OK;
                ld_ms     = ms_sum;
              end else begin
                ld_status = ST_BAD_REPLY;
              end
            end
          end
        end
        default: ;
      endcase
    end else begin
      // idle or done: everything but a start is ignored
    end
  end

  assign produce       = ld_burst || ld_done;
  assign out_take      = out_valid_q && res.ready;
  assign out_last_take = out_take && (out_kind_q == KIND_DONE || beat_q == LAST_BEAT);
  assign out_free      = !out_valid_q || out_last_take;
  assign s1_adv        = s1_valid_q && (!produce || out_free);
  assign req.ready     = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (req.valid && req.ready) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    beat_d      = beat_q;
    if (s1_adv && produce) begin
      out_valid_d = 1'b1;
      beat_d      = '0;
    end else if (out_last_take) begin
      out_valid_d = 1'b0;
    end else if (out_take) begin
      beat_d = beat_q + 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      beat_q      <= '0;
      phase_q     <= PH_IDLE;
      resend_q    <= '0;
      wait_q      <= '0;
      cnt_q       <= '0;
      mode_q      <= '0;
      sec_q       <= '0;
      frac_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      beat_q      <= beat_d;
      if (s1_adv) begin
        phase_q  <= phase_d;
        resend_q <= resend_d;
        wait_q   <= wait_d;
        cnt_q    <= cnt_d;
        mode_q   <= mode_d;
        sec_q    <= sec_d;
        frac_q   <= frac_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      s1_q <= req.data;
    end
    if (s1_adv && produce) begin
      out_kind_q   <= ld_done ? KIND_DONE : KIND_TX_BYTE;
      out_status_q <= ld_status;
      out_ms_q     <= ld_ms;
    end
  end

  // result formatting, query bytes come from the beat counter
  assign res.valid        = out_valid_q;
  assign res.data.kind    = out_kind_q;
  assign res.data.tx_byte = (out_kind_q == KIND_TX_BYTE && beat_q == '0) ? QUERY_BYTE0 : 8'h00;
  assign res.data.last    = out_kind_q == KIND_DONE || beat_q == LAST_BEAT;
  assign res.data.status  = (out_kind_q == KIND_DONE) ? out_status_q : ST_PENDING;
  assign res.data.unix_ms = (out_kind_q == KIND_DONE) ? out_ms_q : '0;

endmodule

>>> tb/sntp_query_reply_engine_tb.sv
// self-checking testbench for the sntp query and reply engine
module sntp_query_reply_engine_tb;
  import sqre_pkg::*;

  // longest run of cycles with no handshake on either channel before giving up
  localparam int unsigned STALL_LIMIT    = 2000;
  // request register, decode and result register, plus margin
  localparam int unsigned SETTLE_CYCLES  = 8;
  // requests that reach a live exchange, per handshake mix
  localparam int unsigned LIVE_PER_PHASE = 36;

  // exchange state as the engine sees it
  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_WAIT,
    ENG_DONE
  } eng_phase_e;

  // how a directed row is checked: by the predictor or by a result typed in the table
  typedef enum logic [2:0] {
    ANS_MODEL,
    ANS_NONE,
    ANS_QUERY,
    ANS_TIMEOUT,
    ANS_TX_FAIL
  } answer_e;

  // shapes of one random exchange
  typedef enum logic [2:0] {
    FL_GOOD,
    FL_BAD_MODE,
    FL_OLD_SECS,
    FL_BROKEN,
    FL_NOISE
  } flavor_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] rx_byte;
    logic       rx_end;
    answer_e    answer;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_reg_e    cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  sqre_req_if req_if ();
  sqre_res_if res_if ();

  sntp_query_reply_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_if),
    .res         (res_if)
  );

  // directed part, run with a zero timeout register and one resend allowed
  dir_row_t directed_tab [20] = '{
    '{CMD_TICK,    8'h00, 1'b0, ANS_NONE},     // idle engine ignores a tick
    '{CMD_RX_BYTE, 8'hff, 1'b1, ANS_NONE},     // ... a received byte
    '{CMD_TX_FAIL, 8'h00, 1'b0, ANS_NONE},     // ... and a send failure
    '{CMD_START,   8'h00, 1'b0, ANS_QUERY},
    '{CMD_RX_BYTE, 8'h24, 1'b0, ANS_NONE},
    '{CMD_RX_BYTE, 8'h00, 1'b1, ANS_NONE},     // short datagram dropped at its end
    '{CMD_START,   8'hff, 1'b1, ANS_QUERY},    // restart while waiting
    '{CMD_TICK,    8'h00, 1'b0, ANS_QUERY},    // zero timeout acts as one tick: resend
    '{CMD_TICK,    8'hff, 1'b1, ANS_TIMEOUT},  // resends used up
    '{CMD_TICK,    8'h00, 1'b0, ANS_NONE},     // done engine ignores traffic
    '{CMD_RX_BYTE, 8'hff, 1'b1, ANS_NONE},
    '{CMD_START,   8'h00, 1'b0, ANS_QUERY},    // restart after completion
    '{CMD_TX_FAIL, 8'hff, 1'b1, ANS_TX_FAIL},
    '{CMD_TX_FAIL, 8'h00, 1'b0, ANS_NONE},
    '{CMD_START,   8'h00, 1'b0, ANS_QUERY},
    '{CMD_RX_BYTE, 8'hff, 1'b0, ANS_MODEL},
    '{CMD_RX_BYTE, 8'h00, 1'b0, ANS_MODEL},
    '{CMD_TICK,    8'h00, 1'b0, ANS_QUERY},    // resend in the middle of a datagram
    '{CMD_RX_BYTE, 8'h80, 1'b1, ANS_MODEL},    // byte count kept across it, still short
    '{CMD_TICK,    8'h00, 1'b0, ANS_TIMEOUT}
  };

  // predicted engine state and register copies
  eng_phase_e  eng_phase;
  logic [3:0]  resends;
  logic [31:0] ticks_waited;
  logic [5:0]  rx_count;
  logic [2:0]  rx_mode;
  logic [31:0] rx_secs;
  logic [31:0] rx_frac;
  logic [31:0] tmo_ticks;
  logic [3:0]  retry_max;

  // results of one request, then the queue of query bytes and completions still owed
  res_t step_out [PACKET_BYTES];
  res_t engine_out_q [$];
  res_t oldest_out;

  logic [7:0] dgram_q [$];

  int unsigned snd_idle_pct;
  int unsigned rcv_stall_pct;
  int unsigned err_cnt      = 0;
  int unsigned live_reqs    = 0;
  int unsigned exch_cnt     = 0;
  int unsigned beats_seen   = 0;
  int unsigned done_seen    = 0;
  int unsigned ok_seen      = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic req_t mk_req(input cmd_e c, input logic [7:0] b, input logic e);
    req_t r;
    r.command = c;
    r.rx_byte = b;
    r.rx_end  = e;
    return r;
  endfunction

  function automatic res_t query_beat(input int unsigned idx);
    res_t beat;
    beat.kind    = KIND_TX_BYTE;
    beat.tx_byte = (idx == 0) ? QUERY_BYTE0 : 8'h00;
    beat.last    = (idx == PACKET_BYTES - 1);
    beat.status  = ST_PENDING;
    beat.unix_ms = '0;
    return beat;
  endfunction

  function automatic res_t done_rec(input status_e st, input logic [40:0] ms);
    res_t rec;
    rec.kind    = KIND_DONE;
    rec.tx_byte = 8'h00;
    rec.last    = 1'b1;
    rec.status  = st;
    rec.unix_ms = (st == ST_OK) ? ms : '0;
    return rec;
  endfunction

  function automatic int unsigned load_query();
    for (int i = 0; i < PACKET_BYTES; i++) step_out[i] = query_beat(i);
    return PACKET_BYTES;
  endfunction

  function automatic int unsigned close_exchange(input status_e st, input logic [40:0] ms);
    eng_phase   = ENG_DONE;
    step_out[0] = done_rec(st, ms);
    return 1;
  endfunction

  // advance the predicted engine by one request; its results land in step_out
  function automatic int unsigned sntp_client_step(input req_t r);
    logic        full;
    logic [63:0] secs_1970;
    logic [63:0] ms;
    if (r.command == CMD_START) begin
      eng_phase    = ENG_WAIT;
      resends      = '0;
      ticks_waited = '0;
      rx_count     = '0;
      return load_query();
    end
    if (eng_phase != ENG_WAIT) return 0;
    case (r.command)
      CMD_TICK: begin
        ticks_waited = ticks_waited + 32'd1;
        // a zero register is met by the first tick
        if (ticks_waited >= tmo_ticks) begin
          if (resends >= retry_max) return close_exchange(ST_TIMEOUT, '0);
          resends      = resends + 4'd1;
          ticks_waited = '0;
          return load_query();
        end
        return 0;
      end
      CMD_TX_FAIL: return close_exchange(ST_TX_FAIL, '0);
      default: begin
        // bytes past the packet size are counted no further and not stored
        if (rx_count < PACKET_BYTES) begin
          if (rx_count == 0) rx_mode = r.rx_byte[2:0];
          else if (rx_count >= 40 && rx_count < 44) rx_secs = {rx_secs[23:0], r.rx_byte};
          else if (rx_count >= 44) rx_frac = {rx_frac[23:0], r.rx_byte};
          rx_count = rx_count + 6'd1;
        end
        if (r.rx_end) begin
          full     = (rx_count >= PACKET_BYTES);
          rx_count = '0;
          if (full) begin
            if (rx_mode != MODE_SERVER && rx_mode != MODE_BROADCAST)
              return close_exchange(ST_BAD_REPLY, '0);
            if (rx_secs < UNIX_EPOCH_SECS) return close_exchange(ST_BAD_REPLY, '0);
            secs_1970 = {32'd0, rx_secs} - {32'd0, UNIX_EPOCH_SECS};
            ms = secs_1970 * 64'd1000 + (({32'd0, rx_frac} * 64'd1000) >> 32);
            return close_exchange(ST_OK, ms[40:0]);
          end
        end
        return 0;
      end
    endcase
  endfunction

  // present one request, wait for it to be taken, then book what it should produce
  task automatic send_req(input req_t r, input answer_e answer);
    int unsigned n;
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    if (r.command == CMD_START || eng_phase == ENG_WAIT) live_reqs++;
    n = sntp_client_step(r);
    case (answer)
      ANS_MODEL:   for (int i = 0; i < n; i++) engine_out_q.push_back(step_out[i]);
      ANS_QUERY:   for (int i = 0; i < PACKET_BYTES; i++) engine_out_q.push_back(query_beat(i));
      ANS_TIMEOUT: engine_out_q.push_back(done_rec(ST_TIMEOUT, '0));
      ANS_TX_FAIL: engine_out_q.push_back(done_rec(ST_TX_FAIL, '0));
      default: ;
    endcase
  endtask

  task automatic send_filler(input cmd_e c);
    send_req(mk_req(c, 8'($urandom), 1'($urandom)), ANS_MODEL);
  endtask

  // the datagram in dgram_q, with the odd tick slipped in between bytes
  task automatic send_dgram();
    foreach (dgram_q[k]) begin
      if ($urandom_range(99) < 8) send_filler(CMD_TICK);
      send_req(mk_req(CMD_RX_BYTE, dgram_q[k], k == dgram_q.size() - 1), ANS_MODEL);
    end
  endtask

  // register writes only while nothing is in flight
  task automatic set_timing(input logic [31:0] tmo, input logic [3:0] retries);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_TIMEOUT;
    cfg_wdata_i <= tmo;
    @(posedge clk_i);
    cfg_idx_i   <= REG_RETRY;
    cfg_wdata_i <= {28'd0, retries};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tmo_ticks = tmo;
    retry_max = retries;
  endtask

  // drop valid, wait for every booked result, then let requests without results drain
  task automatic settle();
    req_if.valid <= 1'b0;
    while (engine_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_exchange(input flavor_e flavor);
    logic [31:0] secs;
    logic [31:0] frac;
    logic [2:0]  mode;
    send_filler(CMD_START);
    case (flavor)
      FL_BROKEN: begin
        // short datagrams, then a send failure, a run of ticks, a datagram cut off or nothing more
        repeat ($urandom_range(1, 2)) begin
          dgram_q.delete();
          repeat ($urandom_range(1, 8)) dgram_q.push_back(8'($urandom));
          send_dgram();
        end
        case ($urandom_range(0, 3))
          0: send_filler(CMD_TX_FAIL);
          1: for (int k = 0; k < 60 && eng_phase == ENG_WAIT; k++) send_filler(CMD_TICK);
          2: repeat ($urandom_range(1, 5)) begin
            send_req(mk_req(CMD_RX_BYTE, 8'($urandom), 1'b0), ANS_MODEL);
          end
          default: ;
        endcase
      end
      FL_NOISE: begin
        repeat ($urandom_range(4, 12)) begin
          send_req(mk_req(cmd_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom)),
                   ANS_MODEL);
        end
      end
      default: begin
        if ($urandom_range(99) < 20) begin
          dgram_q.delete();
          repeat ($urandom_range(1, 6)) dgram_q.push_back(8'($urandom));
          send_dgram();
        end
        dgram_q.delete();
        repeat (PACKET_BYTES) dgram_q.push_back(8'($urandom));
        if (flavor == FL_BAD_MODE) begin
          do mode = 3'($urandom); while (mode == MODE_SERVER || mode == MODE_BROADCAST);
        end else begin
          mode = ($urandom_range(0, 1) == 0) ? MODE_SERVER : MODE_BROADCAST;
        end
        dgram_q[0] = {dgram_q[0][7:3], mode};
        if (flavor == FL_OLD_SECS) begin
          case ($urandom_range(0, 2))
            0:       secs = '0;
            1:       secs = UNIX_EPOCH_SECS - 32'd1;
            default: secs = $urandom_range(0, UNIX_EPOCH_SECS - 32'd1);
          endcase
        end else begin
          case ($urandom_range(0, 2))
            0:       secs = UNIX_EPOCH_SECS;
            1:       secs = 32'hffff_ffff;
            default: secs = $urandom_range(UNIX_EPOCH_SECS, 32'hffff_ffff);
          endcase
        end
        case ($urandom_range(0, 3))
          0:       frac = '0;
          1:       frac = 32'hffff_ffff;
          default: frac = $urandom;
        endcase
        for (int k = 0; k < 4; k++) begin
          dgram_q[40 + k] = secs[31 - 8*k -: 8];
          dgram_q[44 + k] = frac[31 - 8*k -: 8];
        end
        // long datagram: the tail is neither stored nor counted
        if ($urandom_range(99) < 30) repeat ($urandom_range(1, 6)) dgram_q.push_back(8'($urandom));
        send_dgram();
        // stray traffic once the exchange has ended
        if ($urandom_range(99) < 20) begin
          repeat ($urandom_range(1, 3)) send_filler(cmd_e'($urandom_range(1, 3)));
        end
      end
    endcase
  endtask

  task automatic cmp_field(input string fname, input logic [40:0] want,
                           input logic [40:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // result side: random stalls, and every taken result against the oldest one owed
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (engine_out_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with none owed, expected nothing, actual %h", $time, res_if.data);
      end else begin
        oldest_out = engine_out_q.pop_front();
        cmp_field("kind", oldest_out.kind, res_if.data.kind);
        cmp_field("tx_byte", oldest_out.tx_byte, res_if.data.tx_byte);
        cmp_field("last", oldest_out.last, res_if.data.last);
        cmp_field("status", oldest_out.status, res_if.data.status);
        cmp_field("unix_ms", oldest_out.unix_ms, res_if.data.unix_ms);
      end
      if (res_if.data.kind == KIND_DONE) begin
        done_seen++;
        if (res_if.data.status == ST_OK) ok_seen++;
      end else begin
        beats_seen++;
      end
    end
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
      $display("sntp_query_reply_engine_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned goal;
    flavor_e     flavor;
    int unsigned pick;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_TIMEOUT;
    cfg_wdata_i   = '0;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    res_if.ready  = 1'b0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    // predicted state after reset
    eng_phase    = ENG_IDLE;
    resends      = '0;
    ticks_waited = '0;
    rx_count     = '0;
    rx_mode      = '0;
    rx_secs      = '0;
    rx_frac      = '0;
    tmo_ticks    = TIMEOUT_RESET;
    retry_max    = RETRY_RESET;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows: zero timeout register, a single resend allowed
    set_timing(32'd0, 4'd1);
    foreach (directed_tab[k]) begin
      send_req(mk_req(directed_tab[k].cmd, directed_tab[k].rx_byte, directed_tab[k].rx_end),
               directed_tab[k].answer);
    end
    settle();

    // random exchanges under four handshake mixes, each with its own register setting
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
          set_timing(32'hffff_ffff, 4'd15);
        end
        1: begin
          snd_idle_pct  = 63;
          rcv_stall_pct = 0;
          set_timing(TIMEOUT_RESET, RETRY_RESET);
        end
        2: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 63;
          set_timing(32'd3, 4'd15);
        end
        default: begin
          snd_idle_pct  = 11;
          rcv_stall_pct = 11;
          set_timing($urandom_range(1, 12), 4'd0);
        end
      endcase
      goal = live_reqs + LIVE_PER_PHASE;
      while (live_reqs < goal) begin
        // every shape once up front, weighted toward full replies afterwards
        if (exch_cnt < 5) begin
          flavor = flavor_e'(exch_cnt);
        end else begin
          pick = $urandom_range(99);
          if (pick < 40)      flavor = FL_GOOD;
          else if (pick < 50) flavor = FL_BAD_MODE;
          else if (pick < 60) flavor = FL_OLD_SECS;
          else if (pick < 85) flavor = FL_BROKEN;
          else                flavor = FL_NOISE;
        end
        run_exchange(flavor);
        exch_cnt++;
      end
      settle();
    end

    $display("covered %0d live requests in %0d random exchanges plus the directed rows",
             live_reqs, exch_cnt);
    $display("checked %0d query bytes and %0d completions, %0d carrying server time",
             beats_seen, done_seen, ok_seen);
    if (err_cnt == 0) begin
      $display("sntp_query_reply_engine_tb OK");
    end else begin
      $display("sntp_query_reply_engine_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/sqre_pkg.sv
hdl/sqre_if.sv
hdl/sntp_query_reply_engine.sv
tb/sntp_query_reply_engine_tb.sv
